[src/tti_pkg.sv]
// Shared types, constants and helpers for the trajectory time interpolator.
package tti_pkg;

    localparam int W         = 32;
    localparam int NF        = 11;
    localparam int FRAC_BITS = 16;
    localparam int QB        = FRAC_BITS + 1;
    localparam int SW        = 68;

    localparam int F_TIME  = 0;
    localparam int F_SPEED = 1;
    localparam int F_ARC   = 3;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    typedef logic signed [W-1:0] t_q;

    typedef struct packed {
        logic [1:0] action;
        t_q time_in;
        t_q speed_in;
        t_q accel_in;
        t_q arc_in;
        t_q x_in;
        t_q y_in;
        t_q heading_in;
        t_q curvature_in;
        t_q lateral_in;
        t_q left_in;
        t_q right_in;
    } t_item;

    typedef struct packed {
        logic found;
        t_q time_out;
        t_q speed_out;
        t_q accel_out;
        t_q arc_out;
        t_q x_out;
        t_q y_out;
        t_q heading_out;
        t_q curvature_out;
        t_q lateral_out;
        t_q left_out;
        t_q right_out;
    } t_result;

    // index 0 is time, then the fields in item order
    typedef logic [NF-1:0][W-1:0] t_point;

    function automatic t_point to_point(input t_item it);
        t_point p;
        p[0]  = it.time_in;
        p[1]  = it.speed_in;
        p[2]  = it.accel_in;
        p[3]  = it.arc_in;
        p[4]  = it.x_in;
        p[5]  = it.y_in;
        p[6]  = it.heading_in;
        p[7]  = it.curvature_in;
        p[8]  = it.lateral_in;
        p[9]  = it.left_in;
        p[10] = it.right_in;
        return p;
    endfunction

    function automatic t_result to_result(input logic found, input t_point p);
        t_result r;
        r.found         = found;
        r.time_out      = p[0];
        r.speed_out     = p[1];
        r.accel_out     = p[2];
        r.arc_out       = p[3];
        r.x_out         = p[4];
        r.y_out         = p[5];
        r.heading_out   = p[6];
        r.curvature_out = p[7];
        r.lateral_out   = p[8];
        r.left_out      = p[9];
        r.right_out     = p[10];
        return r;
    endfunction

    function automatic t_q sat32(input logic signed [SW-1:0] v);
        t_q r;
        if (v > $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}}))
            r = {1'b0, {(W-1){1'b1}}};
        else if (v < $signed({{(SW-W+1){1'b1}}, {(W-1){1'b0}}}))
            r = {1'b1, {(W-1){1'b0}}};
        else
            r = v[W-1:0];
        return r;
    endfunction

endpackage

[src/tti_div.sv]
// Restoring divider for the interpolation ratio, one quotient bit per cycle.
module tti_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [tti_pkg::W:0]    i_num,
    input  logic [tti_pkg::W:0]    i_den,
    output logic                   o_done,
    output logic [tti_pkg::QB-1:0] o_quot
);
    import tti_pkg::*;

    localparam int CNTW = $clog2(QB + 1);

    logic [W+1:0]   r_rem;
    logic [W:0]     r_den;
    logic [CNTW-1:0] r_cnt;
    logic           r_busy;
    logic           ge;
    logic [W+1:0]   rem_sub;

    // numerator never exceeds the divisor, so QB bits cover the quotient
    assign ge      = r_rem >= {1'b0, r_den};
    assign rem_sub = ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_cnt  <= CNTW'(QB);
            end else if (r_busy) begin
                o_quot <= {o_quot[QB-2:0], ge};
                r_rem  <= {rem_sub[W:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

[src/trajectory_time_interpolator_top.sv]
// Trajectory point table with time lookup and linear interpolation.
//
//  channel  | handshake                | word
//  ---------+--------------------------+-----------------------------
//  command  | start / busy             | i_item (t_item)
//  result   | o_valid, one-cycle pulse | o_result (t_result)
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_data (min_gap)
//
// Clear and append are done without leaving the idle state; busy stays low.
// A query is paced by the single table read port during the search,
// the bit-serial ratio divider and the multiplies done one field at a time.
// Reset is synchronous; it empties the table and sets min_gap to 1.
// Results are a one-cycle strobe; the receiver cannot stall them.
module trajectory_time_interpolator_top #(
    parameter int MAX_POINTS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tti_pkg::t_item   i_item,
    output logic             o_valid,
    output tti_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [15:0]      i_cfg_data
);
    import tti_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_FIRST_W, S_FIRST, S_LAST_W, S_LAST, S_SRCH, S_SRCH_W, S_SRCH_CMP,
        S_NEXT_W, S_NEXT, S_PREV_W, S_PREV, S_DIV, S_MUL, S_ACC, S_ARC_MUL, S_ARC_ADD
    } t_state;

    t_state r_state;
    t_point r_mem [MAX_POINTS];
    t_point r_rd;
    t_point r_next;
    t_point r_prev;
    t_point r_res;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi;
    logic [15:0]   r_min_gap;
    t_q            r_t;
    logic signed [W:0] r_dt_tgt;
    logic          r_div_go;
    logic [QB-1:0] r_ratio;
    logic [3:0]    r_fld;
    logic signed [W+QB:0]   r_prod;
    logic signed [2*W+2:0]  r_aprod;

    logic          accept;
    logic          we;
    logic [CW-1:0] mid;
    logic [CW-1:0] idx;
    logic signed [W:0] dt_tot;
    logic signed [W:0] dt_tgt;
    logic signed [W:0] fdiff;
    logic signed [W+1:0] vsum;
    logic          div_done;
    logic [QB-1:0] div_q;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign we          = accept && i_item.action == ACT_APPEND && r_count < CW'(MAX_POINTS);
    assign mid         = r_lo + ((r_hi - r_lo) >> 1);
    assign idx         = (r_lo == '0) ? CW'(1) :
                         (r_lo >= r_count) ? (r_count - 1'b1) : r_lo;
    assign dt_tot = $signed({r_next[F_TIME][W-1], r_next[F_TIME]})
                  - $signed({r_rd[F_TIME][W-1], r_rd[F_TIME]});
    assign dt_tgt = $signed({r_t[W-1], r_t}) - $signed({r_rd[F_TIME][W-1], r_rd[F_TIME]});
    assign fdiff  = $signed({r_next[r_fld][W-1], r_next[r_fld]})
                  - $signed({r_prev[r_fld][W-1], r_prev[r_fld]});
    assign vsum   = $signed({{2{r_prev[F_SPEED][W-1]}}, r_prev[F_SPEED]})
                  + $signed({{2{r_res[F_SPEED][W-1]}}, r_res[F_SPEED]});

    tti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_dt_tgt),
        .i_den   (r_next[F_TIME] - r_prev[F_TIME] == '0 ? {(W+1){1'b1}} :
                  $unsigned($signed({r_next[F_TIME][W-1], r_next[F_TIME]})
                  - $signed({r_prev[F_TIME][W-1], r_prev[F_TIME]}))),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // point table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (we)
            r_mem[r_count[AW-1:0]] <= to_point(i_item);
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_min_gap <= 16'd1;
            o_valid   <= 1'b0;
            r_div_go  <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            r_div_go <= 1'b0;
            if (i_cfg_valid)
                r_min_gap <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_item.action)
                            ACT_CLEAR:  r_count <= '0;
                            ACT_APPEND: if (we) r_count <= r_count + 1'b1;
                            ACT_QUERY: begin
                                r_t <= i_item.time_in;
                                if (r_count == '0) begin
                                    o_valid  <= 1'b1;
                                    o_result <= '0;
                                end else begin
                                    r_addr  <= '0;
                                    r_state <= S_FIRST_W;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_FIRST_W: r_state <= S_FIRST;
                S_FIRST: begin
                    if (r_t <= $signed(r_rd[F_TIME])) begin
                        o_valid  <= 1'b1;
                        o_result <= to_result(1'b1, r_rd);
                        r_state  <= S_IDLE;
                    end else begin
                        r_addr  <= AW'(r_count - 1'b1);
                        r_state <= S_LAST_W;
                    end
                end
                S_LAST_W: r_state <= S_LAST;
                S_LAST: begin
                    if (r_t >= $signed(r_rd[F_TIME])) begin
                        o_valid  <= 1'b1;
                        o_result <= to_result(1'b1, r_rd);
                        r_state  <= S_IDLE;
                    end else begin
                        r_lo    <= '0;
                        r_hi    <= r_count;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_addr  <= mid[AW-1:0];
                        r_state <= S_SRCH_W;
                    end else begin
                        r_addr  <= idx[AW-1:0];
                        r_state <= S_NEXT_W;
                    end
                end
                S_SRCH_W: r_state <= S_SRCH_CMP;
                S_SRCH_CMP: begin
                    if ($signed(r_rd[F_TIME]) < r_t)
                        r_lo <= mid + 1'b1;
                    else
                        r_hi <= mid;
                    r_state <= S_SRCH;
                end
                S_NEXT_W: r_state <= S_NEXT;
                S_NEXT: begin
                    r_next  <= r_rd;
                    r_addr  <= AW'(idx - 1'b1);
                    r_state <= S_PREV_W;
                end
                S_PREV_W: r_state <= S_PREV;
                S_PREV: begin
                    r_prev   <= r_rd;
                    r_dt_tgt <= dt_tgt;
                    if (dt_tot <= 0 || dt_tot < $signed({17'd0, r_min_gap}) || dt_tgt < 0) begin
                        o_valid  <= 1'b1;
                        o_result <= to_result(1'b1, r_rd);
                        r_state  <= S_IDLE;
                    end else begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_ratio <= div_q;
                        r_fld   <= 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= fdiff * $signed({1'b0, r_ratio});
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_res[r_fld] <= sat32(SW'($signed(r_prev[r_fld]))
                                          + SW'(r_prod >>> FRAC_BITS));
                    if (r_fld == 4'(NF - 1)) begin
                        r_state <= S_ARC_MUL;
                    end else begin
                        r_fld   <= r_fld + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_ARC_MUL: begin
                    r_aprod <= vsum * r_dt_tgt;
                    r_state <= S_ARC_ADD;
                end
                S_ARC_ADD: begin
                    o_valid  <= 1'b1;
                    o_result <= to_result(1'b1, {r_res[NF-1:F_ARC+1],
                                sat32(SW'($signed(r_prev[F_ARC])) + SW'(r_aprod >>> QB)),
                                r_res[F_ARC-1:F_SPEED], r_t});
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result strobe while busy");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS)) else $error("point count overflow");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.action == ACT_QUERY && r_count != '0 |=> busy)
        else $error("query did not start");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.found |-> o_result.speed_out == '0 && o_result.time_out == '0)
        else $error("empty result not zero");

endmodule

[verif/trajectory_time_interpolator_top_tb.sv]
// Self-checking testbench for the trajectory time interpolator: table loads, queries, min_gap.
`timescale 1ns / 100ps

module trajectory_time_interpolator_top_tb;
    import tti_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam logic [1:0] ACT_RSVD = 2'd3;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_item      i_item;
    logic       o_valid;
    t_result    o_result;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [15:0] i_cfg_data;

    trajectory_time_interpolator_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_valid(o_valid), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // Keeps its own copy of the point table and predicts each query answer.
    class interp_scoreboard;
        t_point  pts[TABLE_DEPTH];
        int      npts;
        int      gap;
        t_result pending[$];
        int      errors;
        int      checked;
        int      interp_cnt;

        function new();
            npts = 0; gap = 1; errors = 0; checked = 0; interp_cnt = 0;
        endfunction

        function t_q clip(input longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function t_result answer_query(input t_q t);
            t_point  p;
            int      lo, hi, mid, nx, pv;
            longint  dtot, dtgt, ratio, d, prod, vsum, part, q;
            logic [127:0] mag;
            if (npts == 0) return '0;
            if (t <= $signed(pts[0][0])) return to_result(1'b1, pts[0]);
            if (t >= $signed(pts[npts-1][0])) return to_result(1'b1, pts[npts-1]);
            lo = 0; hi = npts;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if ($signed(pts[mid][0]) < t) lo = mid + 1; else hi = mid;
            end
            nx = (lo == 0) ? 1 : lo;
            if (nx >= npts) nx = npts - 1;
            pv = nx - 1;
            dtot = longint'($signed(pts[nx][0])) - longint'($signed(pts[pv][0]));
            dtgt = longint'(t) - longint'($signed(pts[pv][0]));
            if (dtot <= 0 || dtot < gap || dtgt < 0) return to_result(1'b1, pts[pv]);
            interp_cnt++;
            ratio = (dtgt << FRAC_BITS) / dtot;
            p[0] = t;
            for (int f = 1; f < NF; f++) begin
                d = longint'($signed(pts[nx][f])) - longint'($signed(pts[pv][f]));
                prod = d * ratio;
                p[f] = clip(longint'($signed(pts[pv][f])) + (prod >>> FRAC_BITS));
            end
            // trapezoid: magnitude product shifted right by QB and capped at 2^40, floored toward -inf
            vsum = longint'($signed(pts[pv][F_SPEED])) + longint'($signed(p[F_SPEED]));
            mag = 128'(vsum < 0 ? -vsum : vsum) * 128'(dtgt);
            q = (mag >> QB) > (128'd1 << 40) ? (64'sd1 << 40) : longint'(mag >> QB);
            if (vsum < 0 && mag[QB-1:0] != 0 && q < (64'sd1 << 40)) q++;
            part = vsum < 0 ? -q : q;
            p[F_ARC] = clip(longint'($signed(pts[pv][F_ARC])) + part);
            return to_result(1'b1, p);
        endfunction

        function void note_item(input t_item it);
            case (it.action)
                ACT_CLEAR: npts = 0;
                ACT_APPEND: if (npts < TABLE_DEPTH) begin
                    pts[npts] = to_point(it);
                    npts++;
                end
                ACT_QUERY: pending.push_back(answer_query(it.time_in));
                default: ;
            endcase
        endfunction

        function void check_result(input t_result got);
            t_result e;
            t_point ep, gp;
            string names[NF] = '{"time_out", "speed_out", "accel_out", "arc_out", "x_out",
                "y_out", "heading_out", "curvature_out", "lateral_out", "left_out",
                "right_out"};
            if (pending.size() == 0) begin
                $error("unexpected result word");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.found !== got.found) begin
                $error("found: expected %0d actual %0d", e.found, got.found);
                errors++;
            end
            ep = {e.time_out, e.speed_out, e.accel_out, e.arc_out, e.x_out, e.y_out,
                  e.heading_out, e.curvature_out, e.lateral_out, e.left_out, e.right_out};
            gp = {got.time_out, got.speed_out, got.accel_out, got.arc_out, got.x_out,
                  got.y_out, got.heading_out, got.curvature_out, got.lateral_out,
                  got.left_out, got.right_out};
            // packed index NF-1 is time in this concatenation
            for (int f = 0; f < NF; f++)
                if (ep[NF-1-f] !== gp[NF-1-f]) begin
                    $error("%s: expected %h actual %h", names[f], ep[NF-1-f], gp[NF-1-f]);
                    errors++;
                end
        endfunction
    endclass

    interp_scoreboard sb;
    int   items_sent;
    int   queries_sent;
    t_q   time_cursor;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("[trajectory_time_interpolator_top] ERROR");
        $finish;
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid) sb.check_result(o_result);

    // start stays high after acceptance; the next word or an idle gap takes it over
    task automatic send_word(input t_item it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(it);
        items_sent++;
        if (it.action == ACT_QUERY) queries_sent++;
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_gap(input logic [15:0] g);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= g;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.gap = g;
    endtask

    function automatic t_item rand_point(input t_q t);
        t_item it;
        it.action = ACT_APPEND;
        it.time_in = t;
        it.speed_in = $urandom; it.accel_in = $urandom; it.arc_in = $urandom;
        it.x_in = $urandom; it.y_in = $urandom; it.heading_in = $urandom;
        it.curvature_in = $urandom; it.lateral_in = $urandom;
        it.left_in = $urandom; it.right_in = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            // small values keep interpolation away from saturation
            it.speed_in = $signed($urandom_range(0, 2000000)) - 1000000;
            it.arc_in   = $signed($urandom_range(0, 2000000)) - 1000000;
        end
        return it;
    endfunction

    function automatic t_item op_word(input logic [1:0] a, input t_q t);
        t_item it;
        it = rand_point(t);
        it.action = a;
        return it;
    endfunction

    function automatic t_q query_time();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return time_cursor + $signed($urandom_range(0, 3));
            default: return $signed(time_cursor) - $signed($urandom_range(0, 600000));
        endcase
    endfunction

    initial begin
        t_item it;
        int burst;
        int quiet;
        sb = new();
        items_sent = 0;
        queries_sent = 0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, single point, extremes, clamps, gaps
        send_word(op_word(ACT_QUERY, 32'sh80000000));
        send_word(op_word(ACT_RSVD, 0));
        it = rand_point(32'sh80000000);
        it.speed_in = 32'sh7fffffff; it.arc_in = 32'sh7fffffff;
        send_word(it);
        send_word(op_word(ACT_QUERY, 32'sh7fffffff));
        it = rand_point(32'sh80000001);
        send_word(it);
        it = rand_point(32'sh7fffffff);
        it.speed_in = 32'sh80000000; it.arc_in = 32'sh80000000;
        send_word(it);
        send_word(op_word(ACT_QUERY, 32'sh80000001));
        send_word(op_word(ACT_QUERY, 0));
        send_word(op_word(ACT_QUERY, 32'sh7ffffffe));
        send_word(op_word(ACT_QUERY, 32'sh7fffffff));
        send_word(op_word(ACT_CLEAR, 0));
        send_word(op_word(ACT_QUERY, 5));
        send_word(rand_point(100));
        send_word(rand_point(100));
        send_word(rand_point(50));
        send_word(rand_point(200));
        send_word(op_word(ACT_QUERY, 75));
        send_word(op_word(ACT_QUERY, 150));
        send_word(op_word(ACT_QUERY, 199));
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_gap(16'd0);
                1: write_gap(16'hffff);
                2: write_gap(16'd1);
                default: write_gap($urandom);
            endcase
            send_word(op_word(ACT_CLEAR, 0));
            time_cursor = $signed($urandom_range(0, 4000000)) - 2000000;
            // phase 3 fills the table past its depth to exercise append-when-full
            for (int n = 0; n < (phase == 3 ? 260 : $urandom_range(2, 20)); n++) begin
                time_cursor = time_cursor + $signed($urandom_range(0, 200000));
                send_word(rand_point(time_cursor));
            end
            while (queries_sent < 45 * (phase + 1)) begin
                burst = $urandom_range(1, 12);
                repeat (burst) begin
                    case ($urandom_range(0, 19))
                        0: send_word(op_word(ACT_APPEND, time_cursor + $urandom_range(0, 9000)));
                        1: send_word(rand_point($urandom));
                        2: send_word(op_word(ACT_RSVD, $urandom));
                        default: send_word(op_word(ACT_QUERY, query_time()));
                    endcase
                end
                quiet = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
                idle_cycles(quiet);
            end
            drain();
        end

        $display("covered %0d command words, %0d query results checked, %0d interpolated",
                 items_sent, sb.checked, sb.interp_cnt);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[trajectory_time_interpolator_top] OK");
        else
            $display("[trajectory_time_interpolator_top] ERROR");
        $finish;
    end
endmodule

[trajectory_time_interpolator_top.f]
src/tti_pkg.sv
src/tti_div.sv
src/trajectory_time_interpolator_top.sv
verif/trajectory_time_interpolator_top_tb.sv
